// ----- rtl/mec_pkg.sv -----
// ----------------------------------------------------------------------------
// mec_pkg
// Shared types, constants and fixed-point helpers of the escape counter.
// ----------------------------------------------------------------------------
package mec_pkg;

  localparam int COORD_W   = 32;
  localparam int COUNT_W   = 16;
  localparam int PIX_W     = 12;
  localparam int FRAC_BITS = COORD_W - 5;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int OFS_W     = COORD_W + PIX_W + 1;
  localparam int WIDE_W    = (PROD_W > OFS_W) ? PROD_W : OFS_W;
  localparam int CFG_IDX_W = 3;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [OFS_W-1:0]   ofs_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic [PIX_W-1:0]          pix_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

  // register indexes of the configuration port
  localparam cfg_idx_t REG_REAL_ORIGIN = 3'd0;
  localparam cfg_idx_t REG_IMAG_ORIGIN = 3'd1;
  localparam cfg_idx_t REG_REAL_STEP   = 3'd2;
  localparam cfg_idx_t REG_IMAG_STEP   = 3'd3;
  localparam cfg_idx_t REG_MAX_ITER    = 3'd4;

  localparam count_t MAX_ITER_RST = COUNT_W'(256);

  // 4.0 in the coordinate format
  localparam coord_t FOUR = {3'b001, {(FRAC_BITS + 2){1'b0}}};

  // one point waiting for the iteration engine
  typedef struct packed {
    coord_t cr;
    coord_t ci;
    pix_t   col;
    pix_t   row;
  } point_t;

  // clamp a sum one bit wider than a coordinate
  function automatic coord_t sat_sum(input logic signed [COORD_W:0] s);
    coord_t r;
    if (s[COORD_W] != s[COORD_W-1]) begin
      r = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r = s[COORD_W-1:0];
    end
    return r;
  endfunction

  function automatic coord_t sat_add(input coord_t a, input coord_t b);
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    return sat_sum(s);
  endfunction

  function automatic coord_t sat_sub(input coord_t a, input coord_t b);
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return sat_sum(s);
  endfunction

  // clamp a wide signed value to the coordinate range
  function automatic coord_t sat_wide(input wide_t v);
    coord_t r;
    if ((&v[WIDE_W-1:COORD_W-1]) || !(|v[WIDE_W-1:COORD_W-1])) begin
      r = v[COORD_W-1:0];
    end else begin
      r = v[WIDE_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- rtl/mec_front.sv -----
// ----------------------------------------------------------------------------
// mec_front
// Takes pixel requests and forms the point c for each, one register stage deep.
// ----------------------------------------------------------------------------
module mec_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  mec_pkg::pix_t   in_pixel_col,
  input  mec_pkg::pix_t   in_pixel_row,
  input  mec_pkg::coord_t real_origin,
  input  mec_pkg::coord_t imag_origin,
  input  mec_pkg::coord_t real_step,
  input  mec_pkg::coord_t imag_step,
  output logic            push,
  output mec_pkg::point_t push_data,
  input  logic            q_full
);
  import mec_pkg::*;

  logic s1_valid_r;
  ofs_t ofs_re_r;
  ofs_t ofs_im_r;
  pix_t col_r;
  pix_t row_r;
  logic accept;

  assign busy   = s1_valid_r;
  assign accept = start && !s1_valid_r;
  assign push   = s1_valid_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (push) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ofs_re_r <= OFS_W'($signed({1'b0, in_pixel_col})) * OFS_W'(real_step);
      ofs_im_r <= OFS_W'($signed({1'b0, in_pixel_row})) * OFS_W'(imag_step);
      col_r    <= in_pixel_col;
      row_r    <= in_pixel_row;
    end
  end

  always_comb begin
    push_data.cr  = sat_add(real_origin, sat_wide(WIDE_W'(ofs_re_r)));
    push_data.ci  = sat_add(imag_origin, sat_wide(WIDE_W'(ofs_im_r)));
    push_data.col = col_r;
    push_data.row = row_r;
  end

endmodule

// ----- rtl/mec_queue.sv -----
// ----------------------------------------------------------------------------
// mec_queue
// Short first-in first-out store of points between front and engine.
// ----------------------------------------------------------------------------
module mec_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mec_pkg::point_t push_data,
  output logic            full,
  input  logic            pop,
  output mec_pkg::point_t head,
  output logic            empty
);
  import mec_pkg::*;

  point_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                do_push;
  logic                do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/mec_engine.sv -----
// ----------------------------------------------------------------------------
// mec_engine
// Iterates z = z*z + c for one point at a time, each iteration a multiply state then an update state.
// ----------------------------------------------------------------------------
module mec_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  mec_pkg::count_t max_iterations,
  input  logic            q_empty,
  input  mec_pkg::point_t head,
  output logic            pop,
  output logic            out_valid,
  output mec_pkg::count_t out_escape_count,
  output mec_pkg::pix_t   out_col,
  output mec_pkg::pix_t   out_row
);
  import mec_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  coord_t     cr_r;
  coord_t     ci_r;
  coord_t     zr_r;
  coord_t     zi_r;
  count_t     count_r;
  pix_t       col_r;
  pix_t       row_r;
  prod_t      p_rr_r;
  prod_t      p_ii_r;
  prod_t      p_ri_r;
  logic       out_valid_r;
  count_t     out_count_r;
  pix_t       out_col_r;
  pix_t       out_row_r;

  coord_t zr2;
  coord_t zi2;
  coord_t mag;
  coord_t zr_nxt;
  coord_t zi_nxt;
  prod_t  sh_rr;
  prod_t  sh_ii;
  prod_t  sh_ri;
  logic   keep_going;

  assign pop = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    sh_rr      = p_rr_r >>> FRAC_BITS;
    sh_ii      = p_ii_r >>> FRAC_BITS;
    // doubling folded into the shift
    sh_ri      = p_ri_r >>> (FRAC_BITS - 1);
    zr2        = sat_wide(WIDE_W'(sh_rr));
    zi2        = sat_wide(WIDE_W'(sh_ii));
    mag        = sat_add(zr2, zi2);
    keep_going = (mag < FOUR) && (count_r < max_iterations);
    zr_nxt     = sat_add(sat_sub(zr2, zi2), cr_r);
    zi_nxt     = sat_add(sat_wide(WIDE_W'(sh_ri)), ci_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_UPD;
      ST_UPD: state_nxt = keep_going ? ST_MUL : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_UPD) && !keep_going;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cr_r    <= head.cr;
      ci_r    <= head.ci;
      col_r   <= head.col;
      row_r   <= head.row;
      zr_r    <= '0;
      zi_r    <= '0;
      count_r <= '0;
    end else if (state_r == ST_UPD && keep_going) begin
      zr_r    <= zr_nxt;
      zi_r    <= zi_nxt;
      count_r <= count_r + 1'b1;
    end
    if (state_r == ST_MUL) begin
      p_rr_r <= PROD_W'(zr_r) * PROD_W'(zr_r);
      p_ii_r <= PROD_W'(zi_r) * PROD_W'(zi_r);
      p_ri_r <= PROD_W'(zr_r) * PROD_W'(zi_r);
    end
    if (state_r == ST_UPD && !keep_going) begin
      out_count_r <= count_r;
      out_col_r   <= col_r;
      out_row_r   <= row_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_escape_count = out_count_r;
  assign out_col          = out_col_r;
  assign out_row          = out_row_r;

endmodule

// ----- rtl/mandelbrot_escape_counter.sv -----
// path: c is formed in the front register, the point waits in the queue, then the engine
//   iterates until escape or the iteration limit and registers the result
// flow: one pixel at a time in the engine, each iteration a multiply state
//   then a shift, clamp and add state; the front fills the queue meanwhile
// reset: synchronous; empties front and queue, origins and steps to 0,
//   iteration limit to 256; results are a one-cycle strobe the receiver cannot stall
// ----------------------------------------------------------------------------
// mandelbrot_escape_counter
// Escape-time counter for one pixel per request in signed Q5.27 fixed point.
// ----------------------------------------------------------------------------
module mandelbrot_escape_counter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mec_pkg::pix_t     in_pixel_col,
  input  mec_pkg::pix_t     in_pixel_row,
  output logic              out_valid,
  output mec_pkg::count_t   out_escape_count,
  output mec_pkg::pix_t     out_col,
  output mec_pkg::pix_t     out_row,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  mec_pkg::cfg_idx_t cfg_index,
  input  mec_pkg::coord_t   cfg_data
);
  import mec_pkg::*;

  coord_t real_origin_r;
  coord_t imag_origin_r;
  coord_t real_step_r;
  coord_t imag_step_r;
  count_t max_iter_r;

  logic   push;
  point_t push_data;
  logic   q_full;
  logic   q_empty;
  logic   pop;
  point_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_origin_r <= '0;
      imag_origin_r <= '0;
      real_step_r   <= '0;
      imag_step_r   <= '0;
      max_iter_r    <= MAX_ITER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REAL_ORIGIN: real_origin_r <= cfg_data;
        REG_IMAG_ORIGIN: imag_origin_r <= cfg_data;
        REG_REAL_STEP:   real_step_r   <= cfg_data;
        REG_IMAG_STEP:   imag_step_r   <= cfg_data;
        REG_MAX_ITER:    max_iter_r    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  mec_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_pixel_col (in_pixel_col),
    .in_pixel_row (in_pixel_row),
    .real_origin  (real_origin_r),
    .imag_origin  (imag_origin_r),
    .real_step    (real_step_r),
    .imag_step    (imag_step_r),
    .push         (push),
    .push_data    (push_data),
    .q_full       (q_full)
  );

  mec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  mec_engine u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .max_iterations   (max_iter_r),
    .q_empty          (q_empty),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_escape_count (out_escape_count),
    .out_col          (out_col),
    .out_row          (out_row)
  );

endmodule
